// File: hw/rtl/ghd_pkg.sv
// ----------------------------------------------------------------------------
// ghd_pkg
// Shared constants, register codes and stage types for the grid heuristic
// distance block.
// ----------------------------------------------------------------------------
package ghd_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int GRID_W         = 9;
  localparam int DIST_W         = 9;
  localparam int MODE_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd3;

  localparam logic [MODE_W-1:0] MODE_EUCLID    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MANHATTAN = 2'd1;

  localparam logic [GRID_W-1:0] WIDTH_RST  = 9'd20;
  localparam logic [GRID_W-1:0] HEIGHT_RST = 9'd17;
  localparam logic [MODE_W-1:0] MODE_RST   = MODE_EUCLID;

  localparam int LANE_CELL = 0;
  localparam int LANE_TGT  = 1;

  // sum of squares, padded to an even width for the two-bit root steps
  localparam int SQ_W     = 2 * GRID_W + 2;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int SREM_W   = ROOT_W + 1;
  localparam int ALT_W    = GRID_W + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic [GRID_W-1:0] col;
    logic [GRID_W-1:0] row;
  } ghd_coord_t;

  typedef struct packed {
    logic [SQ_W-1:0]   val;
    logic [ROOT_W-1:0] root;
    logic [SREM_W-1:0] rem;
    logic [ALT_W-1:0]  alt;
    logic              euclid;
  } ghd_sq_t;

endpackage

// File: hw/rtl/ghd_if.sv
// ----------------------------------------------------------------------------
// ghd_if
// Request channels of the grid heuristic distance block: cell index in,
// distance out, register writes.
// ----------------------------------------------------------------------------
interface ghd_in_if #(
  parameter int INDEX_BITS = ghd_pkg::INDEX_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] cell_index;

  modport source (output valid, output cell_index, input ready);
  modport sink   (input valid, input cell_index, output ready);
endinterface

interface ghd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ghd_pkg::DIST_W-1:0]  distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

interface ghd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ghd_pkg::CFG_IDX_W-1:0]   index;
  logic [ghd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/ghd_div_cell.sv
// ----------------------------------------------------------------------------
// ghd_div_cell
// One restoring-division step for both lanes (cell, target): one quotient bit
// set in place; keeps the partial remainder or, if LATCH_COL, moves it to col.
// ----------------------------------------------------------------------------
module ghd_div_cell #(
  parameter int INDEX_BITS = ghd_pkg::INDEX_BITS_DEF,
  parameter int BIT        = 0,
  parameter bit LATCH_COL  = 1'b0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [ghd_pkg::GRID_W-1:0]           divisor,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0][INDEX_BITS-1:0]           in_num,
  input  logic [1:0][ghd_pkg::GRID_W-1:0]      in_rem,
  input  logic [1:0][ghd_pkg::GRID_W-1:0]      in_col,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0][INDEX_BITS-1:0]           out_num,
  output logic [1:0][ghd_pkg::GRID_W-1:0]      out_rem,
  output logic [1:0][ghd_pkg::GRID_W-1:0]      out_col
);
  import ghd_pkg::*;

  logic                       valid_r;
  logic [1:0][INDEX_BITS-1:0] num_r, num_nxt;
  logic [1:0][GRID_W-1:0]     rem_r, rem_nxt;
  logic [1:0][GRID_W-1:0]     col_r, col_nxt;
  logic [1:0][GRID_W:0]       shifted;
  logic [1:0][GRID_W:0]       diff;
  logic [1:0][GRID_W-1:0]     rem_q;
  logic [1:0]                 ge;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_num   = num_r;
  assign out_rem   = rem_r;
  assign out_col   = col_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      shifted[l]     = {in_rem[l], in_num[l][BIT]};
      diff[l]        = shifted[l] - {1'b0, divisor};
      ge[l]          = shifted[l] >= {1'b0, divisor};
      rem_q[l]       = ge[l] ? diff[l][GRID_W-1:0] : shifted[l][GRID_W-1:0];
      num_nxt[l]     = in_num[l];
      num_nxt[l][BIT] = ge[l];
      if (LATCH_COL) begin
        col_nxt[l] = rem_q[l];
        rem_nxt[l] = '0;
      end else begin
        col_nxt[l] = in_col[l];
        rem_nxt[l] = rem_q[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// File: hw/rtl/ghd_metric_cell.sv
// ----------------------------------------------------------------------------
// ghd_metric_cell
// Coordinate differences, sum of squares for the root chain and the
// Manhattan or Chebyshev figure for the other modes.
// ----------------------------------------------------------------------------
module ghd_metric_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ghd_pkg::MODE_W-1:0]    mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ghd_pkg::ghd_coord_t           cell_xy,
  input  ghd_pkg::ghd_coord_t           tgt_xy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ghd_pkg::ghd_sq_t              out_sq
);
  import ghd_pkg::*;

  logic                  valid_r;
  ghd_sq_t               sq_r, sq_nxt;
  logic [GRID_W-1:0]     dx, dy, dmax;
  logic [2*GRID_W-1:0]   dx2, dy2;
  logic [ALT_W-1:0]      dsum;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_sq    = sq_r;

  always_comb begin
    dx   = (tgt_xy.col > cell_xy.col) ? tgt_xy.col - cell_xy.col : cell_xy.col - tgt_xy.col;
    dy   = (tgt_xy.row > cell_xy.row) ? tgt_xy.row - cell_xy.row : cell_xy.row - tgt_xy.row;
    dx2  = dx * dx;
    dy2  = dy * dy;
    dsum = ALT_W'(dx) + ALT_W'(dy);
    dmax = (dx > dy) ? dx : dy;
    sq_nxt.val    = SQ_W'(dx2) + SQ_W'(dy2);
    sq_nxt.root   = '0;
    sq_nxt.rem    = '0;
    sq_nxt.alt    = (mode == MODE_MANHATTAN) ? dsum : ALT_W'(dmax);
    sq_nxt.euclid = (mode == MODE_EUCLID);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sq_r <= sq_nxt;
    end
  end

endmodule

// File: hw/rtl/ghd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ghd_sqrt_cell
// One digit-by-digit integer square root step: brings down two radicand
// bits and resolves one root bit.
// ----------------------------------------------------------------------------
module ghd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ghd_pkg::ghd_sq_t  in_sq,
  output logic              out_valid,
  input  logic              out_ready,
  output ghd_pkg::ghd_sq_t  out_sq
);
  import ghd_pkg::*;

  logic              valid_r;
  ghd_sq_t           sq_r, sq_nxt;
  logic [SREM_W+1:0] cur;
  logic [SREM_W+1:0] trial;
  logic [SREM_W+1:0] diff;
  logic              ge;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_sq    = sq_r;

  always_comb begin
    cur    = {in_sq.rem, in_sq.val[SQ_W-1-2*STEP -: 2]};
    trial  = (SREM_W+2)'({in_sq.root, 2'b01});
    diff   = cur - trial;
    ge     = cur >= trial;
    sq_nxt = in_sq;
    sq_nxt.rem  = ge ? diff[SREM_W-1:0] : cur[SREM_W-1:0];
    sq_nxt.root = {in_sq.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sq_r <= sq_nxt;
    end
  end

endmodule

// File: hw/rtl/grid_heuristic_distance.sv
// ----------------------------------------------------------------------------
// grid_heuristic_distance
// Path-search heuristic from a linear cell index to a configured goal cell:
// Euclidean, Manhattan or Chebyshev over wrapped grid coordinates.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while out_ch is not stalled; each stage
//   holds its own item, so bubbles fill while a result waits at the output
//   register. Items pass the two restoring-divider chains (one bit per cell),
//   the metric cell, the ten-step square-root chain and the output register.
// Reset: all stage valids cleared, registers back to width 20, height 17,
//   target 0, Euclidean mode. No clearing pass.
module grid_heuristic_distance #(
  parameter int INDEX_BITS = ghd_pkg::INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ghd_in_if.sink    in_ch,
  ghd_out_if.source out_ch,
  ghd_cfg_if.sink   cfg_ch
);
  import ghd_pkg::*;

  localparam int N_DIV = 2 * INDEX_BITS;

  logic [GRID_W-1:0]     width_r, height_r;
  logic [INDEX_BITS-1:0] target_r;
  logic [MODE_W-1:0]     mode_r;
  logic [GRID_W-1:0]     w_eff, h_eff;

  logic [N_DIV:0]                dv, dr;
  logic [1:0][INDEX_BITS-1:0]    dnum [N_DIV+1];
  logic [1:0][GRID_W-1:0]        drem [N_DIV+1];
  logic [1:0][GRID_W-1:0]        dcol [N_DIV+1];

  logic [SQ_STEPS:0] sv, sr;
  ghd_sq_t           sq [SQ_STEPS+1];

  ghd_coord_t        cell_xy, tgt_xy;

  logic              out_valid_r;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [ALT_W-1:0]  d_sel;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      target_r <= '0;
      mode_r   <= MODE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GRID_WIDTH:  width_r  <= cfg_ch.data[GRID_W-1:0];
        REG_GRID_HEIGHT: height_r <= cfg_ch.data[GRID_W-1:0];
        REG_TARGET:      target_r <= cfg_ch.data[INDEX_BITS-1:0];
        REG_MODE:        mode_r   <= cfg_ch.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero width or height wraps as one
  assign w_eff = (width_r == '0)  ? GRID_W'(1) : width_r;
  assign h_eff = (height_r == '0) ? GRID_W'(1) : height_r;

  // divider chain: index / width, then quotient / height
  assign dv[0]       = in_ch.valid;
  assign in_ch.ready = dr[0];

  always_comb begin
    dnum[0]            = '0;
    dnum[0][LANE_CELL] = in_ch.cell_index;
    dnum[0][LANE_TGT]  = target_r;
    drem[0]            = '0;
    dcol[0]            = '0;
  end

  for (genvar g = 0; g < N_DIV; g++) begin : g_div
    ghd_div_cell #(
      .INDEX_BITS (INDEX_BITS),
      .BIT        (INDEX_BITS - 1 - (g % INDEX_BITS)),
      .LATCH_COL  (g == INDEX_BITS - 1)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   ((g < INDEX_BITS) ? w_eff : h_eff),
      .in_valid  (dv[g]),
      .in_ready  (dr[g]),
      .in_num    (dnum[g]),
      .in_rem    (drem[g]),
      .in_col    (dcol[g]),
      .out_valid (dv[g+1]),
      .out_ready (dr[g+1]),
      .out_num   (dnum[g+1]),
      .out_rem   (drem[g+1]),
      .out_col   (dcol[g+1])
    );
  end

  assign cell_xy.col = dcol[N_DIV][LANE_CELL];
  assign cell_xy.row = drem[N_DIV][LANE_CELL];
  assign tgt_xy.col  = dcol[N_DIV][LANE_TGT];
  assign tgt_xy.row  = drem[N_DIV][LANE_TGT];

  ghd_metric_cell u_metric (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_valid  (dv[N_DIV]),
    .in_ready  (dr[N_DIV]),
    .cell_xy   (cell_xy),
    .tgt_xy    (tgt_xy),
    .out_valid (sv[0]),
    .out_ready (sr[0]),
    .out_sq    (sq[0])
  );

  // square-root chain
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    ghd_sqrt_cell #(
      .STEP (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sv[k]),
      .in_ready  (sr[k]),
      .in_sq     (sq[k]),
      .out_valid (sv[k+1]),
      .out_ready (sr[k+1]),
      .out_sq    (sq[k+1])
    );
  end

  // mode select, saturation and output register
  assign sr[SQ_STEPS] = !out_valid_r || out_ch.ready;

  always_comb begin
    d_sel    = sq[SQ_STEPS].euclid ? ALT_W'(sq[SQ_STEPS].root) : sq[SQ_STEPS].alt;
    dist_nxt = (d_sel > ALT_W'(DIST_MAX)) ? DIST_MAX : d_sel[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sr[SQ_STEPS]) begin
      out_valid_r <= sv[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (sv[SQ_STEPS] && sr[SQ_STEPS]) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.distance = dist_r;

endmodule

// File: dv/tb_grid_heuristic_distance.sv
// ----------------------------------------------------------------------------
// tb_grid_heuristic_distance
// Self-checking bench for the grid heuristic distance block. A short table of
// directed requests covers reset values, grid extremes, zero and oversized
// dimensions, saturation and every distance mode. Random phases follow, each
// with fresh register settings. An in-bench model predicts distances the table
// omits; results are checked in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_grid_heuristic_distance;
  timeunit 1ns;
  timeprecision 1ps;

  import ghd_pkg::*;

  localparam int IDX_W        = INDEX_BITS_DEF;
  localparam int RANDOM_CELLS = 1850;
  localparam int CALM_TAIL    = 250;
  localparam int SETTLE       = 2 * IDX_W + SQ_STEPS + 18;

  localparam logic [MODE_W-1:0] MODE_CHEBYSHEV     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CHEBYSHEV_ALT = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_CELL} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [IDX_W-1:0]      cidx;
    bit                    typed;
    logic [DIST_W-1:0]     want;
  } plan_row_t;

  logic clk   = 1'b0;
  logic rst_n;

  ghd_in_if #(.INDEX_BITS(IDX_W)) in_ch ();
  ghd_out_if                      out_ch ();
  ghd_cfg_if                      cfg_ch ();

  grid_heuristic_distance #(.INDEX_BITS(IDX_W)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // register shadow
  logic [GRID_W-1:0] grid_w     = WIDTH_RST;
  logic [GRID_W-1:0] grid_h     = HEIGHT_RST;
  logic [IDX_W-1:0]  goal_index = '0;
  logic [MODE_W-1:0] dist_mode  = MODE_RST;

  logic [DIST_W-1:0] dist_due[$];
  plan_row_t         plan[$];

  bit quiet = 1'b0;
  int faults       = 0;
  int cells_sent   = 0;
  int dists_seen   = 0;
  int settings_run = 0;

  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 10; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] cell_distance(input logic [IDX_W-1:0] cidx);
    int unsigned w, h, cx, cy, tx, ty, dx, dy, d;
    w  = (grid_w == 0) ? 1 : grid_w;
    h  = (grid_h == 0) ? 1 : grid_h;
    cx = cidx % w;
    cy = (cidx / w) % h;
    tx = goal_index % w;
    ty = (goal_index / w) % h;
    dx = (cx > tx) ? cx - tx : tx - cx;
    dy = (cy > ty) ? cy - ty : ty - cy;
    case (dist_mode)
      MODE_EUCLID:    d = floor_root(dx * dx + dy * dy);
      MODE_MANHATTAN: d = dx + dy;
      default:        d = (dx > dy) ? dx : dy;
    endcase
    if (d > DIST_MAX) d = DIST_MAX;
    return d[DIST_W-1:0];
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t cell_row(input logic [IDX_W-1:0] cidx, input bit typed,
                                         input logic [DIST_W-1:0] want);
    plan_row_t r;
    r = '{ROW_CELL, REG_GRID_WIDTH, '0, cidx, typed, want};
    return r;
  endfunction

  function automatic void add_row(input plan_row_t r);
    plan = {plan, r};
  endfunction

  function automatic logic [GRID_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 9'd1;
      2:       return 9'd256;
      3:       return 9'd511;
      4:       return GRID_W'($urandom_range(257, 511));
      5:       return GRID_W'($urandom_range(2, 8));
      default: return GRID_W'($urandom_range(1, 256));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_cell();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2, 3:    return goal_index;
      4, 5:    return goal_index + IDX_W'($urandom_range(0, 8)) - IDX_W'(4);
      default: return IDX_W'($urandom);
    endcase
  endfunction

  task automatic note_fault(input string what, input logic [DIST_W-1:0] want,
                            input logic [DIST_W-1:0] got);
    faults++;
    if (faults <= 10)
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_GRID_WIDTH:  grid_w     = data[GRID_W-1:0];
      REG_GRID_HEIGHT: grid_h     = data[GRID_W-1:0];
      REG_TARGET:      goal_index = data[IDX_W-1:0];
      REG_MODE:        dist_mode  = data[MODE_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cell(input logic [IDX_W-1:0] cidx, input bit typed,
                           input logic [DIST_W-1:0] want);
    in_ch.valid      <= 1'b1;
    in_ch.cell_index <= cidx;
    do @(posedge clk); while (!in_ch.ready);
    dist_due = {dist_due, (typed ? want : cell_distance(cidx))};
    cells_sent++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (dist_due.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs();
    logic [CFG_DATA_W-1:0] d;
    d = $urandom; d[GRID_W-1:0] = pick_dim();
    write_reg(REG_GRID_WIDTH, d);
    d = $urandom; d[GRID_W-1:0] = pick_dim();
    write_reg(REG_GRID_HEIGHT, d);
    d = $urandom;
    write_reg(REG_TARGET, d);
    d = $urandom;
    write_reg(REG_MODE, d);
    settings_run++;
  endtask

  // result side: ready in random bursts
  initial begin
    int unsigned run;
    bit stalled;
    run = 0;
    stalled = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        stalled = 1'b0;
        run = 0;
      end else if (run != 0) begin
        run--;
      end else if (!stalled && $urandom_range(0, 2) == 0) begin
        stalled = 1'b1;
        run = $urandom_range(1, 14) - 1;
      end else begin
        stalled = 1'b0;
        run = $urandom_range(1, 40) - 1;
      end
      out_ch.ready <= !stalled;
    end
  end

  always @(posedge clk) begin
    logic [DIST_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      dists_seen++;
      if (dist_due.size() == 0) begin
        note_fault("distance with no request outstanding", 'x, out_ch.distance);
      end else begin
        want = dist_due.pop_front();
        if (out_ch.distance !== want) note_fault("distance mismatch", want, out_ch.distance);
      end
    end
  end

  initial begin
    #3_200_000;
    $display("timeout with %0d distances outstanding", dist_due.size());
    $display("tb_grid_heuristic_distance: errors");
    $finish;
  end

  initial begin
    int phase_len;
    int random_sent;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cell_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_GRID_WIDTH;
    cfg_ch.data      <= '0;

    // reset grid 20 x 17, goal 0, Euclidean
    add_row(cell_row(16'h0000, 1'b1, 9'd0));
    add_row(cell_row(16'hFFFF, 1'b0, '0));
    add_row(cell_row(16'd21, 1'b0, '0));
    add_row(write_row(REG_MODE, 32'(MODE_MANHATTAN)));
    add_row(cell_row(16'hFFFF, 1'b0, '0));
    add_row(write_row(REG_MODE, 32'(MODE_CHEBYSHEV)));
    add_row(cell_row(16'hFFFF, 1'b0, '0));
    add_row(write_row(REG_MODE, 32'hFFFF_FFFC | 32'(MODE_CHEBYSHEV_ALT)));
    add_row(cell_row(16'hFFFF, 1'b0, '0));
    add_row(write_row(REG_TARGET, 32'hA5A5_FFFF));
    add_row(cell_row(16'hFFFF, 1'b1, 9'd0));
    // zero width: column always 0
    add_row(write_row(REG_GRID_WIDTH, 32'hFFFF_FE00));
    add_row(cell_row(16'h1234, 1'b0, '0));
    // zero height: row always 0
    add_row(write_row(REG_GRID_HEIGHT, 32'h8000_0200));
    add_row(write_row(REG_GRID_WIDTH, 32'd256));
    add_row(write_row(REG_MODE, 32'(MODE_MANHATTAN)));
    add_row(write_row(REG_TARGET, 32'd0));
    add_row(cell_row(16'h00FF, 1'b1, 9'd255));
    add_row(cell_row(16'hFF00, 1'b1, 9'd0));
    add_row(cell_row(16'hFFFF, 1'b1, 9'd255));
    // oversized grid, saturating distances
    add_row(write_row(REG_GRID_WIDTH, 32'd511));
    add_row(write_row(REG_GRID_HEIGHT, 32'd511));
    add_row(write_row(REG_MODE, 32'(MODE_EUCLID)));
    add_row(cell_row(16'hFF7F, 1'b1, DIST_MAX));
    add_row(cell_row(16'hFFFF, 1'b0, '0));
    add_row(write_row(REG_GRID_WIDTH, 32'd300));
    add_row(write_row(REG_MODE, 32'(MODE_MANHATTAN)));
    add_row(cell_row(16'hFF77, 1'b1, DIST_MAX));
    // full 256 x 256 grid, opposite corners
    add_row(write_row(REG_GRID_WIDTH, 32'd256));
    add_row(write_row(REG_GRID_HEIGHT, 32'd256));
    add_row(write_row(REG_MODE, 32'(MODE_CHEBYSHEV)));
    add_row(cell_row(16'hFFFF, 1'b1, 9'd255));
    add_row(write_row(REG_MODE, 32'(MODE_EUCLID)));
    add_row(cell_row(16'hFFFF, 1'b1, 9'd360));
    add_row(write_row(REG_TARGET, 32'h0000_FFFF));
    add_row(cell_row(16'h0000, 1'b1, 9'd360));
    // single-column and single-cell grids
    add_row(write_row(REG_GRID_WIDTH, 32'd1));
    add_row(write_row(REG_MODE, 32'(MODE_MANHATTAN)));
    add_row(write_row(REG_TARGET, 32'd0));
    add_row(cell_row(16'h12FF, 1'b1, 9'd255));
    add_row(write_row(REG_GRID_HEIGHT, 32'd1));
    add_row(cell_row(16'hABCD, 1'b1, 9'd0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        sender_gap();
        send_cell(plan[k].cidx, plan[k].typed, plan[k].want);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_CELLS) begin
      drain();
      program_regs();
      quiet = (random_sent >= RANDOM_CELLS - CALM_TAIL) || ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(40, 120);
      for (int n = 0; n < phase_len && random_sent < RANDOM_CELLS; n++) begin
        sender_gap();
        send_cell(pick_cell(), 1'b0, '0);
        random_sent++;
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (dist_due.size() != 0) note_fault("distance never returned", dist_due[0], 'x);

    $display("%0d cell requests over %0d random register settings plus a directed table",
             cells_sent, settings_run);
    $display("%0d distances returned, %0d mismatches", dists_seen, faults);
    if (faults == 0) begin
      $display("tb_grid_heuristic_distance: clean");
    end else begin
      $display("tb_grid_heuristic_distance: errors");
    end
    $finish;
  end

endmodule
